// ===== hdl/ptp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared constants, command and status codes, and request/result types for
// the priority table with promote.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int TABLE_DEPTH    = 64;
  localparam int PAYLOAD_WIDTH  = 32;
  localparam int PRIORITY_WIDTH = 16;
  localparam int ID_W           = $clog2(TABLE_DEPTH);
  // id counter also holds TABLE_DEPTH itself (table full)
  localparam int ID_CNT_W       = ID_W + 1;
  localparam int CMD_W          = 3;
  localparam int STATUS_W       = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PROMOTE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_IS_VALID = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET_MAX  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_POP_MAX  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [ID_W-1:0]          entry_id;
    logic [PAYLOAD_WIDTH-1:0] payload_in;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]           result_id;
    logic [PAYLOAD_WIDTH-1:0]  result_payload;
    logic [PRIORITY_WIDTH-1:0] result_priority;
    logic                      is_live;
    logic [STATUS_W-1:0]       status;
  } rsp_t;

endpackage

// ===== hdl/priority_table_with_promote.sv =====
// ----------------------------------------------------------------------------
// priority_table_with_promote: add/promote/get table with max search.
// Each request goes from S_EXEC to S_DONE; get and promote pass S_LOOKUP,
// get_max and pop_max scan every entry, then S_FETCH (skipped if none is live).
// One request at a time: the next is taken the cycle after the result is
// registered, and a stalled result holds off the next.
// Reset clears live bits, id counter and control; RAMs keep contents, no sweep.
// ----------------------------------------------------------------------------
module priority_table_with_promote import ptp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_LOOKUP = 6'b000100,
    S_SCAN   = 6'b001000,
    S_FETCH  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t                    state;
  req_t                      req_q;
  rsp_t                      res;
  logic [ID_CNT_W-1:0]       next_free_id;
  logic [TABLE_DEPTH-1:0]    live;
  logic [ID_CNT_W-1:0]       scan_addr;
  logic                      cmp_valid;
  logic [ID_W-1:0]           cmp_idx;
  logic                      found;
  logic [ID_W-1:0]           best_idx;
  logic [PRIORITY_WIDTH-1:0] best_pri;

  logic                      full;
  logic                      id_live;
  logic                      out_free;
  logic                      pri_we;
  logic [ID_W-1:0]           pri_addr;
  logic [PRIORITY_WIDTH-1:0] pri_wdata;
  logic [PRIORITY_WIDTH-1:0] pri_rdata;
  logic                      pay_we;
  logic [ID_W-1:0]           pay_addr;
  logic [PAYLOAD_WIDTH-1:0]  pay_rdata;

  assign req_stall = (state != S_IDLE);
  assign full      = (next_free_id == ID_CNT_W'(TABLE_DEPTH));
  assign id_live   = (ID_CNT_W'(req_q.entry_id) < next_free_id) && live[req_q.entry_id];
  assign out_free  = !rsp_valid || !rsp_stall;

  // entry storage
  ptp_ram #(.WIDTH(PRIORITY_WIDTH), .DEPTH(TABLE_DEPTH)) u_pri_ram (
    .clk   (clk),
    .we    (pri_we),
    .addr  (pri_addr),
    .wdata (pri_wdata),
    .rdata (pri_rdata)
  );

  ptp_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(TABLE_DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .addr  (pay_addr),
    .wdata (req_q.payload_in),
    .rdata (pay_rdata)
  );

  // RAM port control
  always_comb begin
    pri_we    = 1'b0;
    pay_we    = 1'b0;
    pri_addr  = req_q.entry_id;
    pay_addr  = req_q.entry_id;
    pri_wdata = '0;
    unique case (state)
      S_EXEC: begin
        // add writes a fresh entry at the next id
        if (req_q.command == CMD_ADD && !full) begin
          pri_we   = 1'b1;
          pay_we   = 1'b1;
          pri_addr = next_free_id[ID_W-1:0];
          pay_addr = next_free_id[ID_W-1:0];
        end
      end
      S_LOOKUP: begin
        // promote: saturating increment written back
        if (req_q.command == CMD_PROMOTE) begin
          pri_we    = 1'b1;
          pri_wdata = (pri_rdata == '1) ? pri_rdata : pri_rdata + PRIORITY_WIDTH'(1);
        end
      end
      S_SCAN: begin
        pri_addr = scan_addr[ID_W-1:0];
        pay_addr = best_idx;   // used on the cycle the scan ends
      end
      default: begin
      end
    endcase
  end

  // result valid: set when a result is loaded, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      next_free_id <= '0;
      live         <= '0;
      cmp_valid    <= 1'b0;
      found        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req_data;
            res   <= '0;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          state <= S_DONE;
          unique case (req_q.command) inside
            CMD_ADD: begin
              if (full) begin
                res.status <= ST_FULL;
              end else begin
                res.result_id                   <= next_free_id[ID_W-1:0];
                live[next_free_id[ID_W-1:0]]    <= 1'b1;
                next_free_id                    <= next_free_id + ID_CNT_W'(1);
              end
            end
            CMD_PROMOTE, CMD_GET: begin
              if (id_live) begin
                state <= S_LOOKUP;
              end else begin
                res.status <= ST_BAD_ID;
              end
            end
            CMD_IS_VALID: begin
              res.is_live <= id_live;
            end
            CMD_GET_MAX, CMD_POP_MAX: begin
              scan_addr <= '0;
              cmp_valid <= 1'b0;
              found     <= 1'b0;
              state     <= S_SCAN;
            end
            default: begin
            end
          endcase
        end

        S_LOOKUP: begin
          if (req_q.command == CMD_GET) begin
            res.result_payload <= pay_rdata;
          end
          state <= S_DONE;
        end

        S_SCAN: begin
          // compare the entry read last cycle; ties go to the higher id
          if (cmp_valid && live[cmp_idx] && (!found || pri_rdata >= best_pri)) begin
            found    <= 1'b1;
            best_idx <= cmp_idx;
            best_pri <= pri_rdata;
          end
          if (scan_addr != ID_CNT_W'(TABLE_DEPTH)) begin
            cmp_valid <= 1'b1;
            cmp_idx   <= scan_addr[ID_W-1:0];
            scan_addr <= scan_addr + ID_CNT_W'(1);
          end else begin
            cmp_valid <= 1'b0;
            // last compare done: payload read of the winner is issued now
            if (!cmp_valid) begin
              if (found) begin
                state <= S_FETCH;
              end else begin
                res.status <= ST_EMPTY;
                state      <= S_DONE;
              end
            end
          end
        end

        S_FETCH: begin
          res.result_id       <= best_idx;
          res.result_payload  <= pay_rdata;
          res.result_priority <= best_pri;
          if (req_q.command == CMD_POP_MAX) begin
            live[best_idx] <= 1'b0;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            rsp_data <= res;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/ptp_ram.sv =====
// ----------------------------------------------------------------------------
// ptp_ram
// Generic single-port synchronous RAM, one read or write per cycle, read
// data registered.
// ----------------------------------------------------------------------------
module ptp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
